/* hw/rtl/sexl_pkg.sv */
// Shared types and constants of the S-expression lexer.
package sexl_pkg;

    // Character classes, decided once at the front.
    typedef enum logic [3:0] {
        CL_OPEN,
        CL_CLOSE,
        CL_DOT,
        CL_SPACE,
        CL_SIGN,
        CL_DIGIT,
        CL_LETTER,
        CL_NUL,
        CL_OTHER
    } t_cls;

    // One queued character together with its class.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last;
        t_cls       cls;
    } t_item;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] KIND_OPEN   = 3'd0;
    localparam logic [2:0] KIND_CLOSE  = 3'd1;
    localparam logic [2:0] KIND_DOT    = 3'd2;
    localparam logic [2:0] KIND_SPACE  = 3'd3;
    localparam logic [2:0] KIND_NUMBER = 3'd4;
    localparam logic [2:0] KIND_SYMBOL = 3'd5;
    localparam logic [2:0] KIND_END    = 3'd6;
    localparam logic [2:0] KIND_ERROR  = 3'd7;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_INVALID = 2'd1;
    localparam logic [1:0] ERR_SIGN    = 2'd2;
    localparam logic [1:0] ERR_ATOM    = 2'd3;

    localparam logic [7:0] CHAR_OPEN   = 8'h28;
    localparam logic [7:0] CHAR_CLOSE  = 8'h29;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

endpackage

/* hw/rtl/sexl_front.sv */
// Front end: takes input requests and classifies each character.
module sexl_front (
    input  logic              i_in_valid,
    input  logic [7:0]        i_text_byte,
    input  logic              i_last_of_string,
    input  logic              i_queue_full,
    output logic              o_in_ready,
    output logic              o_push,
    output sexl_pkg::t_item   o_item
);

    sexl_pkg::t_cls w_cls;

    always_comb begin
        if (i_text_byte == sexl_pkg::CHAR_OPEN) begin
            w_cls = sexl_pkg::CL_OPEN;
        end else if (i_text_byte == sexl_pkg::CHAR_CLOSE) begin
            w_cls = sexl_pkg::CL_CLOSE;
        end else if (i_text_byte == sexl_pkg::CHAR_DOT) begin
            w_cls = sexl_pkg::CL_DOT;
        end else if (i_text_byte == sexl_pkg::CHAR_SPACE ||
                     (i_text_byte >= 8'h09 && i_text_byte <= 8'h0D)) begin
            w_cls = sexl_pkg::CL_SPACE;
        end else if (i_text_byte == sexl_pkg::CHAR_PLUS ||
                     i_text_byte == sexl_pkg::CHAR_MINUS) begin
            w_cls = sexl_pkg::CL_SIGN;
        end else if (i_text_byte >= 8'h30 && i_text_byte <= 8'h39) begin
            w_cls = sexl_pkg::CL_DIGIT;
        end else if ((i_text_byte >= 8'h41 && i_text_byte <= 8'h5A) ||
                     (i_text_byte >= 8'h61 && i_text_byte <= 8'h7A)) begin
            w_cls = sexl_pkg::CL_LETTER;
        end else if (i_text_byte == sexl_pkg::CHAR_NUL) begin
            w_cls = sexl_pkg::CL_NUL;
        end else begin
            w_cls = sexl_pkg::CL_OTHER;
        end
    end

    assign o_in_ready       = !i_queue_full;
    assign o_push           = i_in_valid && !i_queue_full;
    assign o_item.text_byte = i_text_byte;
    assign o_item.last      = i_last_of_string;
    assign o_item.cls       = w_cls;

endmodule

/* hw/rtl/sexl_queue.sv */
// Short queue of classified characters between front and back.
module sexl_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sexl_pkg::t_item   i_item,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_head_valid,
    output sexl_pkg::t_item   o_head
);

    localparam int DEPTH = sexl_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sexl_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic w_do_pop;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign w_do_pop     = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTH
    // front must never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
`endif

endmodule

/* hw/rtl/sexl_back.sv */
// Back end: lexer state machine and output register.
module sexl_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  sexl_pkg::t_item   i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_token_kind,
    output logic [7:0]        o_token_char,
    output logic              o_starts_token,
    output logic [1:0]        o_error_code,
    output logic              o_run_last
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_SPACE,
        M_SIGN,
        M_NUMBER,
        M_SYMBOL,
        M_ERR_INVALID,
        M_ERR_SIGN,
        M_ERR_ATOM
    } t_mode;

    t_mode      r_mode;
    logic       r_end_pending;
    logic       r_out_valid;
    logic [2:0] r_kind;
    logic [7:0] r_char;
    logic       r_start;
    logic [1:0] r_code;
    logic       r_last;

    t_mode      n_mode;
    logic [2:0] n_kind;
    logic [7:0] n_char;
    logic       n_start;
    logic [1:0] n_code;
    logic [1:0] w_end_code;
    logic       w_load;
    logic       w_delim;

    sexl_pkg::t_cls w_cls;

    assign w_cls   = i_head.cls;
    assign w_load  = i_head_valid && (!r_out_valid || i_out_ready);
    assign o_pop   = w_load && (r_end_pending || !i_head.last);
    assign w_delim = (w_cls == sexl_pkg::CL_OPEN)  || (w_cls == sexl_pkg::CL_CLOSE) ||
                     (w_cls == sexl_pkg::CL_DOT)   || (w_cls == sexl_pkg::CL_SPACE) ||
                     (w_cls == sexl_pkg::CL_NUL);

    // token result for the head character
    always_comb begin
        n_mode  = r_mode;
        n_kind  = sexl_pkg::KIND_ERROR;
        n_char  = i_head.text_byte;
        n_start = 1'b1;
        n_code  = sexl_pkg::ERR_NONE;
        unique case (r_mode) inside
            M_ERR_INVALID, M_ERR_SIGN, M_ERR_ATOM: begin
                n_start = 1'b0;
                n_code  = (r_mode == M_ERR_INVALID) ? sexl_pkg::ERR_INVALID :
                          (r_mode == M_ERR_SIGN)    ? sexl_pkg::ERR_SIGN :
                                                      sexl_pkg::ERR_ATOM;
            end
            M_SIGN: begin
                if (w_cls == sexl_pkg::CL_DIGIT) begin
                    n_kind  = sexl_pkg::KIND_NUMBER;
                    n_start = 1'b0;
                    n_mode  = M_NUMBER;
                end else begin
                    n_code = sexl_pkg::ERR_SIGN;
                    n_mode = M_ERR_SIGN;
                end
            end
            default: begin
                if (r_mode == M_NUMBER && w_cls == sexl_pkg::CL_DIGIT) begin
                    n_kind  = sexl_pkg::KIND_NUMBER;
                    n_start = 1'b0;
                end else if (r_mode == M_SYMBOL && (w_cls == sexl_pkg::CL_DIGIT ||
                             w_cls == sexl_pkg::CL_LETTER)) begin
                    n_kind  = sexl_pkg::KIND_SYMBOL;
                    n_start = 1'b0;
                end else if (r_mode == M_SPACE && w_cls == sexl_pkg::CL_SPACE) begin
                    n_kind  = sexl_pkg::KIND_SPACE;
                    n_char  = sexl_pkg::CHAR_SPACE;
                    n_start = 1'b0;
                end else if ((r_mode == M_NUMBER || r_mode == M_SYMBOL) && !w_delim) begin
                    n_code = sexl_pkg::ERR_ATOM;
                    n_mode = M_ERR_ATOM;
                end else begin
                    // fresh token
                    unique case (w_cls)
                        sexl_pkg::CL_OPEN: begin
                            n_kind = sexl_pkg::KIND_OPEN;
                            n_mode = M_IDLE;
                        end
                        sexl_pkg::CL_CLOSE: begin
                            n_kind = sexl_pkg::KIND_CLOSE;
                            n_mode = M_IDLE;
                        end
                        sexl_pkg::CL_DOT: begin
                            n_kind = sexl_pkg::KIND_DOT;
                            n_mode = M_IDLE;
                        end
                        sexl_pkg::CL_SPACE: begin
                            n_kind = sexl_pkg::KIND_SPACE;
                            n_char = sexl_pkg::CHAR_SPACE;
                            n_mode = M_SPACE;
                        end
                        sexl_pkg::CL_SIGN: begin
                            n_kind = sexl_pkg::KIND_NUMBER;
                            n_mode = M_SIGN;
                        end
                        sexl_pkg::CL_DIGIT: begin
                            n_kind = sexl_pkg::KIND_NUMBER;
                            n_mode = M_NUMBER;
                        end
                        sexl_pkg::CL_LETTER: begin
                            n_kind = sexl_pkg::KIND_SYMBOL;
                            n_mode = M_SYMBOL;
                        end
                        default: begin
                            n_code = sexl_pkg::ERR_INVALID;
                            n_mode = M_ERR_INVALID;
                        end
                    endcase
                end
            end
        endcase
    end

    // end-of-string code from the mode the last character left behind
    always_comb begin
        unique case (r_mode)
            M_ERR_INVALID: w_end_code = sexl_pkg::ERR_INVALID;
            M_ERR_SIGN:    w_end_code = sexl_pkg::ERR_SIGN;
            M_ERR_ATOM:    w_end_code = sexl_pkg::ERR_ATOM;
            M_SIGN:        w_end_code = sexl_pkg::ERR_SIGN;
            default:       w_end_code = sexl_pkg::ERR_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= M_IDLE;
            r_end_pending <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                if (r_end_pending) begin
                    r_mode        <= M_IDLE;
                    r_end_pending <= 1'b0;
                end else begin
                    r_mode        <= n_mode;
                    r_end_pending <= i_head.last;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_load) begin
            if (r_end_pending) begin
                r_kind  <= sexl_pkg::KIND_END;
                r_char  <= '0;
                r_start <= 1'b1;
                r_code  <= w_end_code;
                r_last  <= 1'b1;
            end else begin
                r_kind  <= n_kind;
                r_char  <= n_char;
                r_start <= n_start;
                r_code  <= n_code;
                r_last  <= !i_head.last;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_token_kind   = r_kind;
    assign o_token_char   = r_char;
    assign o_starts_token = r_start;
    assign o_error_code   = r_code;
    assign o_run_last     = r_last;

`ifndef SYNTH
    // while an end result is owed, the token before it sits in the output
    a_end_follows_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end_pending |-> (r_out_valid && !r_last && r_kind != sexl_pkg::KIND_END))
        else $error("end pending without its token in the output register");

    // an error result always carries a code
    a_error_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == sexl_pkg::KIND_ERROR) |-> (r_code != sexl_pkg::ERR_NONE))
        else $error("error result without error code");

    // the end result closes the string: lexer is back to idle
    a_end_resets_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == sexl_pkg::KIND_END) |->
            (r_start && r_last && r_char == '0 && !r_end_pending &&
             ($past(r_end_pending) == 1'b0 || r_mode == M_IDLE)))
        else $error("malformed end-of-string result");
`endif

endmodule

/* hw/rtl/s_expression_lexer.sv */
// Top level of the S-expression lexer: front classifier, queue and back state machine.
//
// Tags one ASCII character per request as part of a token (open, close, dot,
// space run, number with optional sign, symbol) and follows the last character
// of each string with an end-of-string result that carries the string's error
// code. Errors are sticky to the end of the string; on a nonzero code the
// consumer discards all tokens of that string. Throughput is one character per
// cycle and one result per cycle while i_out_ready stays high and the queue has
// room: a character marked last_of_string yields two results, both given by the
// single output register of the back state machine. An accepted character is
// written into the queue, and the output register then loads its first result
// from the queue head.
// The two-entry queue between the classifier and the state machine lets the
// input side keep taking characters while a result waits on i_out_ready.
module s_expression_lexer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_last_of_string,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_token_kind,
    output logic [7:0] o_token_char,
    output logic       o_starts_token,
    output logic [1:0] o_error_code,
    output logic       o_run_last
);

    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_head_valid;
    sexl_pkg::t_item w_item;
    sexl_pkg::t_item w_head;

    // character classification at the input
    sexl_front u_front (
        .i_in_valid       (i_in_valid),
        .i_text_byte      (i_text_byte),
        .i_last_of_string (i_last_of_string),
        .i_queue_full     (w_full),
        .o_in_ready       (o_in_ready),
        .o_push           (w_push),
        .o_item           (w_item)
    );

    // decouples input acceptance from output stalls
    sexl_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_item       (w_item),
        .i_pop        (w_pop),
        .o_full       (w_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    // lexer mode, sticky errors and end-of-string insertion
    sexl_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (w_head_valid),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_kind   (o_token_kind),
        .o_token_char   (o_token_char),
        .o_starts_token (o_starts_token),
        .o_error_code   (o_error_code),
        .o_run_last     (o_run_last)
    );

endmodule

/* sim/s_expression_lexer_tb.sv */
// Testbench of the S-expression lexer: directed and random strings checked by a token predictor.
`timescale 1ns / 100ps

module s_expression_lexer_tb;

    // Lexer state as the predictor tracks it; the three error states hold the
    // sticky code as their distance from MD_SYMBOL.
    typedef enum logic [2:0] {
        MD_IDLE,
        MD_SPACE,
        MD_SIGN,
        MD_NUMBER,
        MD_SYMBOL,
        MD_ERR_INVALID,
        MD_ERR_SIGN,
        MD_ERR_ATOM
    } t_lex_mode;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        logic       start;
        logic [1:0] code;
        logic       run_last;
    } t_token;

    // Predicts the tokens of each accepted request and checks results in order.
    class t_token_tracker;
        t_lex_mode mode;
        t_token    pending_tokens[$];
        int        n_requests;
        int        n_errors;

        function new();
            mode       = MD_IDLE;
            n_requests = 0;
            n_errors   = 0;
        endfunction

        static function bit is_ws(logic [7:0] c);
            return c == sexl_pkg::CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        static function bit is_digit(logic [7:0] c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        static function bit is_letter(logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        endfunction

        function void note_request(logic [7:0] c, logic is_last);
            t_token t;
            t_token eos;
            t.kind     = sexl_pkg::KIND_ERROR;
            t.ch       = c;
            t.start    = 1'b0;
            t.code     = sexl_pkg::ERR_NONE;
            t.run_last = !is_last;
            if (mode >= MD_ERR_INVALID) begin
                // sticky error: every later byte repeats the code
                t.code = 2'(mode - MD_SYMBOL);
            end else if (mode == MD_SIGN) begin
                if (is_digit(c)) begin
                    t.kind = sexl_pkg::KIND_NUMBER;
                    mode   = MD_NUMBER;
                end else begin
                    t.code  = sexl_pkg::ERR_SIGN;
                    t.start = 1'b1;
                    mode    = MD_ERR_SIGN;
                end
            end else if (mode == MD_NUMBER && is_digit(c)) begin
                t.kind = sexl_pkg::KIND_NUMBER;
            end else if (mode == MD_SYMBOL && (is_letter(c) || is_digit(c))) begin
                t.kind = sexl_pkg::KIND_SYMBOL;
            end else if (mode == MD_SPACE && is_ws(c)) begin
                t.kind = sexl_pkg::KIND_SPACE;
                t.ch   = sexl_pkg::CHAR_SPACE;
            end else if ((mode == MD_NUMBER || mode == MD_SYMBOL) &&
                         !(c == sexl_pkg::CHAR_OPEN || c == sexl_pkg::CHAR_CLOSE ||
                           c == sexl_pkg::CHAR_DOT || is_ws(c) ||
                           c == sexl_pkg::CHAR_NUL)) begin
                t.code  = sexl_pkg::ERR_ATOM;
                t.start = 1'b1;
                mode    = MD_ERR_ATOM;
            end else begin
                // byte opens a new token
                t.start = 1'b1;
                if (c == sexl_pkg::CHAR_OPEN) begin
                    t.kind = sexl_pkg::KIND_OPEN;
                    mode   = MD_IDLE;
                end else if (c == sexl_pkg::CHAR_CLOSE) begin
                    t.kind = sexl_pkg::KIND_CLOSE;
                    mode   = MD_IDLE;
                end else if (c == sexl_pkg::CHAR_DOT) begin
                    t.kind = sexl_pkg::KIND_DOT;
                    mode   = MD_IDLE;
                end else if (is_ws(c)) begin
                    t.kind = sexl_pkg::KIND_SPACE;
                    t.ch   = sexl_pkg::CHAR_SPACE;
                    mode   = MD_SPACE;
                end else if (c == sexl_pkg::CHAR_PLUS || c == sexl_pkg::CHAR_MINUS) begin
                    t.kind = sexl_pkg::KIND_NUMBER;
                    mode   = MD_SIGN;
                end else if (is_digit(c)) begin
                    t.kind = sexl_pkg::KIND_NUMBER;
                    mode   = MD_NUMBER;
                end else if (is_letter(c)) begin
                    t.kind = sexl_pkg::KIND_SYMBOL;
                    mode   = MD_SYMBOL;
                end else begin
                    t.code = sexl_pkg::ERR_INVALID;
                    mode   = MD_ERR_INVALID;
                end
            end
            pending_tokens = {pending_tokens, t};
            if (is_last) begin
                eos.kind     = sexl_pkg::KIND_END;
                eos.ch       = sexl_pkg::CHAR_NUL;
                eos.start    = 1'b1;
                eos.run_last = 1'b1;
                if (mode >= MD_ERR_INVALID) begin
                    eos.code = 2'(mode - MD_SYMBOL);
                end else if (mode == MD_SIGN) begin
                    eos.code = sexl_pkg::ERR_SIGN;
                end else begin
                    eos.code = sexl_pkg::ERR_NONE;
                end
                pending_tokens = {pending_tokens, eos};
                mode = MD_IDLE;
            end
            n_requests++;
        endfunction

        function void check_result(t_token got);
            t_token want;
            if (pending_tokens.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected token: kind %0d char %h start %b code %0d last %b",
                         $time, got.kind, got.ch, got.start, got.code, got.run_last);
                return;
            end
            want = pending_tokens.pop_front();
            if (got !== want) begin
                n_errors++;
                $display("%0t: token mismatch: expected kind %0d char %h start %b code %0d last %b",
                         $time, want.kind, want.ch, want.start, want.code, want.run_last);
                $display("%0t:                 actual   kind %0d char %h start %b code %0d last %b",
                         $time, got.kind, got.ch, got.start, got.code, got.run_last);
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] text_byte;
    logic       last_of_string;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] token_kind;
    logic [7:0] token_char;
    logic       starts_token;
    logic [1:0] error_code;
    logic       run_last;

    t_token_tracker tracker;

    s_expression_lexer dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_text_byte      (text_byte),
        .i_last_of_string (last_of_string),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_token_kind     (token_kind),
        .o_token_char     (token_char),
        .o_starts_token   (starts_token),
        .o_error_code     (error_code),
        .o_run_last       (run_last)
    );

    always #5 clk = ~clk;

    // Random idling on both sides, except for a stretch of requests in the
    // middle of the run where both ends stream flat out.
    function automatic bit gaps_on();
        return tracker.n_requests < 900 || tracker.n_requests >= 1300;
    endfunction

    function automatic logic [7:0] ws_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 0) ? sexl_pkg::CHAR_SPACE : 8'(8'h08 + r);
    endfunction

    function automatic logic [7:0] digit_char();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] alnum_char();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0) begin
            return digit_char();
        end
        return 8'((r == 1 ? 8'h41 : 8'h61) + $urandom_range(0, 25));
    endfunction

    // Offer one character; called and returns at a falling edge.
    task automatic send_request(input logic [7:0] c, input logic is_last);
        while (gaps_on() && $urandom_range(0, 99) < 15) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        text_byte      <= c;
        last_of_string <= is_last;
        do @(posedge clk); while (!in_ready);
        tracker.note_request(c, is_last);
        @(negedge clk);
    endtask

    task automatic send_word(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_request(s[i], i == s.len() - 1);
        end
    endtask

    // Mostly well-formed token sequences with random content; a share of the
    // strings get one byte overwritten at random, a few are pure noise.
    task automatic send_random_string();
        logic [7:0] chars[$];
        logic [2:0] pick;
        bit         prev_atom;
        bit         signed_num;
        int         n_dig;
        prev_atom = 1'b0;
        if ($urandom_range(0, 99) < 5) begin
            repeat ($urandom_range(1, 6)) chars = {chars, 8'($urandom_range(0, 255))};
        end else begin
            repeat ($urandom_range(1, 6)) begin
                pick = 3'($urandom_range(0, 5));
                // atoms must be separated by a delimiter
                if (prev_atom && (pick == sexl_pkg::KIND_NUMBER ||
                                  pick == sexl_pkg::KIND_SYMBOL)) begin
                    chars = {chars, ws_char()};
                end
                case (pick)
                    sexl_pkg::KIND_OPEN:  chars = {chars, sexl_pkg::CHAR_OPEN};
                    sexl_pkg::KIND_CLOSE: chars = {chars, sexl_pkg::CHAR_CLOSE};
                    sexl_pkg::KIND_DOT:   chars = {chars, sexl_pkg::CHAR_DOT};
                    sexl_pkg::KIND_SPACE: begin
                        repeat ($urandom_range(1, 3)) chars = {chars, ws_char()};
                    end
                    sexl_pkg::KIND_NUMBER: begin
                        signed_num = ($urandom_range(0, 99) < 30);
                        n_dig      = $urandom_range(1, 4);
                        if (signed_num) begin
                            chars = {chars, ($urandom_range(0, 1) ? sexl_pkg::CHAR_PLUS
                                                                  : sexl_pkg::CHAR_MINUS)};
                            // occasionally a bare sign
                            if ($urandom_range(0, 99) < 10) begin
                                n_dig = 0;
                            end
                        end
                        repeat (n_dig) chars = {chars, digit_char()};
                    end
                    default: begin
                        chars = {chars, 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) +
                                           $urandom_range(0, 25))};
                        repeat ($urandom_range(0, 4)) chars = {chars, alnum_char()};
                    end
                endcase
                prev_atom = (pick == sexl_pkg::KIND_NUMBER || pick == sexl_pkg::KIND_SYMBOL);
            end
            if ($urandom_range(0, 99) < 15) begin
                chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
            end
        end
        foreach (chars[i]) begin
            send_request(chars[i], i == chars.size() - 1);
        end
    endtask

    // Result side: random ready, plus one long hold-off once traffic is under
    // way so the queue fills and the input side has to stall.
    initial begin : receiver
        int  hold_cycles;
        bit  hold_done;
        hold_cycles = 0;
        hold_done   = 1'b0;
        out_ready   = 1'b0;
        forever begin
            @(negedge clk);
            if (!hold_done && tracker.n_requests >= 500) begin
                hold_done   = 1'b1;
                hold_cycles = 400;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= !gaps_on() || $urandom_range(0, 99) >= 15;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            tracker.check_result({token_kind, token_char, starts_token, error_code, run_last});
        end
    end

    initial begin : stimulus
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        text_byte      = 8'h00;
        last_of_string = 1'b0;
        tracker        = new();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // brackets, signed number, space run, symbol
        send_word("(+5 ab)");
        // dot and every whitespace byte from 09 to 0D as one run
        send_word(".\t\n\v\f\r");
        // sign without digit, then sticky error
        send_word("-x(");
        // number followed by a letter
        send_word("9z");
        // NUL ends a number, then is itself invalid
        send_request(8'h37, 1'b0);
        send_request(sexl_pkg::CHAR_NUL, 1'b1);
        // high bytes are invalid
        send_request(8'h80, 1'b0);
        send_request(8'hFF, 1'b1);
        // bare sign as the whole string
        send_word("+");
        // number ended by a dot
        send_word("1.a");

        while (tracker.n_requests < 1900) begin
            send_random_string();
        end
        in_valid <= 1'b0;

        while (tracker.pending_tokens.size() != 0) @(posedge clk);
        // keep watching the output to catch stray results
        repeat (10) @(posedge clk);
        if (tracker.n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
